// File: hw/rtl/msc_pkg.sv
`default_nettype none
package msc_pkg;

  localparam int BufDepth    = 2048;
  localparam int BufAw       = $clog2(BufDepth);
  localparam int BaseDelay   = 336;
  localparam int ModSpan     = 144;
  localparam int SineEntries = 1024;
  localparam int SineAw      = $clog2(SineEntries);
  localparam int RomAw       = SineAw + 1;
  localparam int MaxDelay    = (BufDepth - 1) * 256 - 1;
  localparam int DlyW        = $clog2(MaxDelay + 1) + 2;
  localparam int MaxVoices   = 4;
  localparam int QuotShift   = 20;

  typedef logic [14:0] sine_rom_t [0:SineEntries];

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_PHASE,
    ST_SINE,
    ST_DELAY,
    ST_TAP_A,
    ST_TAP_B,
    ST_TAP_C,
    ST_MIX_1,
    ST_MIX_2,
    ST_MIX_3,
    ST_MIX_4,
    ST_MIX_5,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    REG_BYPASS,
    REG_STEREO,
    REG_PHASE_STEP,
    REG_MOD_DEPTH,
    REG_WET_GAIN,
    REG_VOICE_COUNT
  } reg_idx_e;

  function automatic sine_rom_t sine_rom_init();
    sine_rom_t   rom;
    logic [63:0] th;
    logic [63:0] t2;
    logic [63:0] a;
    logic [63:0] s;
    for (int k = 0; k <= SineEntries; k++) begin
      th = (64'(k) * 64'd1686629713) / SineEntries;
      t2 = (th * th) >> 30;
      a  = (64'd1 << 30) - t2 / 72;
      a  = (64'd1 << 30) - ((t2 * a) >> 30) / 42;
      a  = (64'd1 << 30) - ((t2 * a) >> 30) / 20;
      a  = (64'd1 << 30) - ((t2 * a) >> 30) / 6;
      s  = (th * a) >> 30;
      s  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
      rom[k] = (s > 64'd32767) ? 15'h7fff : s[14:0];
    end
    return rom;
  endfunction

  function automatic logic [31:0] voice_offset(input logic [1:0] v, input logic [2:0] n);
    logic [31:0] off;
    case (n)
      3'd2: off = {v[0], 31'b0};
      3'd3: begin
        case (v)
          2'd1:    off = 32'd1431655765;
          2'd2:    off = 32'd2863311530;
          default: off = 32'd0;
        endcase
      end
      3'd4: off = {v, 30'b0};
      default: off = 32'd0;
    endcase
    return off;
  endfunction

  // Scale factor whose product, shifted down by QuotShift, divides by the voice count.
  function automatic logic [21:0] recip_scale(input logic [2:0] n);
    logic [21:0] k;
    case (n)
      3'd2:    k = 22'(1 << (QuotShift - 1));
      3'd3:    k = 22'd349526;
      3'd4:    k = 22'(1 << (QuotShift - 2));
      default: k = 22'(1 << QuotShift);
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/multi_voice_stereo_chorus.sv
`default_nettype none
// Stereo chorus on two 2048-entry delay lines. Each accepted beat writes one Q1.15 pair and
// reads 1 to 4 modulated, linearly interpolated taps per channel through a single shared
// multiplier. Each tap steps through the phase, sine, delay and tap states, then each channel
// has a wet/dry mix, and the input is not ready meanwhile. In bypass a beat goes straight to
// the output register; the delay lines, write pointer and LFO phase do not change. Delay line
// entries not yet written since reset read as zero, so no clearing pass is needed.
module multi_voice_stereo_chorus
  import msc_pkg::*;
(
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               psel,
  input  wire               penable,
  input  wire               pwrite,
  input  wire        [4:0]  paddr,
  input  wire        [31:0] pwdata,
  output logic       [31:0] prdata,
  output logic              pready,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  wire signed [15:0] in_left_i,
  input  wire signed [15:0] in_right_i,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output logic signed [15:0] out_left_o,
  output logic signed [15:0] out_right_o
);

  localparam sine_rom_t SineRom = sine_rom_init();

  logic              bypass_q;
  logic              stereo_q;
  logic [23:0]       phase_step_q;
  logic [15:0]       mod_depth_q;
  logic [15:0]       wet_gain_q;
  logic [2:0]        voice_count_q;

  state_e            state_q, state_d;
  logic signed [15:0] in_l_q, in_r_q;
  logic [BufAw-1:0]  w_q;
  logic              full_q;
  logic [31:0]       lfo_q;
  logic [1:0]        voice_q;
  logic              ch_q;
  logic              neg_q;
  logic [14:0]       rom_q;
  logic signed [49:0] prod_q;
  logic [7:0]        f_q;
  logic [BufAw-1:0]  addr_b_q;
  logic signed [15:0] rdl_q, rdr_q;
  logic              rvalid_q;
  logic signed [26:0] acc_l_q, acc_r_q;
  logic signed [44:0] tmp_q;
  logic [19:0]       t_q;
  logic              sgn_q;
  logic signed [15:0] res_l_q, res_r_q;
  logic signed [15:0] out_l_q, out_r_q;
  logic              out_valid_q;

  logic signed [15:0] left_mem  [0:BufDepth-1];
  logic signed [15:0] right_mem [0:BufDepth-1];

  logic [2:0]        vcnt;
  logic              last_tap;
  logic              out_load;
  logic              cfg_we;
  logic [31:0]       ph;
  logic [SineAw-1:0] pos;
  logic [RomAw-1:0]  rom_addr;
  logic [38:0]       dmag;
  logic [15:0]       off;
  logic signed [DlyW-1:0] dl;
  logic [BufAw-1:0]  dint;
  logic [7:0]        ffrac;
  logic [BufAw-1:0]  addr_a;
  logic [BufAw-1:0]  rd_addr;
  logic signed [15:0] tap_data;
  logic signed [15:0] in_c;
  logic signed [26:0] acc_c;
  logic signed [27:0] mul_a;
  logic signed [21:0] mul_b;
  logic signed [49:0] prod_d;
  logic signed [44:0] p8;
  logic signed [44:0] tmp_d;
  logic signed [44:0] num;
  logic [44:0]       mag;
  logic [44:0]       rnd;
  logic [19:0]       quo;
  logic signed [15:0] sat;

  assign vcnt = (voice_count_q == 3'd0) ? 3'd1 :
                (voice_count_q > 3'(MaxVoices)) ? 3'(MaxVoices) : voice_count_q;
  assign last_tap = ch_q && (3'(voice_q) == vcnt - 3'd1);
  assign out_load = !out_valid_q || out_ready_i;
  assign cfg_we   = psel && penable && pwrite;
  assign pready   = 1'b1;

  always_comb begin
    case (reg_idx_e'(paddr[4:2]))
      REG_BYPASS:      prdata = {31'b0, bypass_q};
      REG_STEREO:      prdata = {31'b0, stereo_q};
      REG_PHASE_STEP:  prdata = {8'b0, phase_step_q};
      REG_MOD_DEPTH:   prdata = {16'b0, mod_depth_q};
      REG_WET_GAIN:    prdata = {16'b0, wet_gain_q};
      REG_VOICE_COUNT: prdata = {29'b0, voice_count_q};
      default:         prdata = 32'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bypass_q      <= 1'b0;
      stereo_q      <= 1'b1;
      phase_step_q  <= 24'd89478;
      mod_depth_q   <= 16'd32768;
      wet_gain_q    <= 16'd32768;
      voice_count_q <= 3'd2;
    end else if (cfg_we) begin
      case (reg_idx_e'(paddr[4:2]))
        REG_BYPASS:      bypass_q      <= pwdata[0];
        REG_STEREO:      stereo_q      <= pwdata[0];
        REG_PHASE_STEP:  phase_step_q  <= pwdata[23:0];
        REG_MOD_DEPTH:   mod_depth_q   <= pwdata[15:0];
        REG_WET_GAIN:    wet_gain_q    <= pwdata[15:0];
        REG_VOICE_COUNT: voice_count_q <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = bypass_q ? ST_DONE : ST_WRITE;
      ST_WRITE: state_d = ST_PHASE;
      ST_PHASE: state_d = ST_SINE;
      ST_SINE:  state_d = ST_DELAY;
      ST_DELAY: state_d = ST_TAP_A;
      ST_TAP_A: state_d = ST_TAP_B;
      ST_TAP_B: state_d = ST_TAP_C;
      ST_TAP_C: state_d = last_tap ? ST_MIX_1 : ST_PHASE;
      ST_MIX_1: state_d = ST_MIX_2;
      ST_MIX_2: state_d = ST_MIX_3;
      ST_MIX_3: state_d = ST_MIX_4;
      ST_MIX_4: state_d = ST_MIX_5;
      ST_MIX_5: state_d = ch_q ? ST_DONE : ST_MIX_1;
      ST_DONE:  if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
  end

  always_comb begin
    ph       = lfo_q + voice_offset(voice_q, vcnt) + {1'b0, ch_q, 30'b0};
    pos      = ph[29 -: SineAw];
    rom_addr = ph[30] ? (RomAw'(SineEntries) - {1'b0, pos}) : {1'b0, pos};

    dmag  = 39'(prod_q[30:0]) * 39'(ModSpan);
    off   = dmag[38:23];
    dl    = neg_q ? (DlyW'(BaseDelay * 256) - DlyW'(off)) : (DlyW'(BaseDelay * 256) + DlyW'(off));
    if (dl < 0) begin
      dl = '0;
    end else if (dl > DlyW'(MaxDelay)) begin
      dl = DlyW'(MaxDelay);
    end
    dint   = dl[BufAw+7:8];
    ffrac  = dl[7:0];
    addr_a = w_q - dint;
    rd_addr = (state_q == ST_DELAY) ? addr_a : addr_b_q;

    tap_data = rvalid_q ? (ch_q ? rdr_q : rdl_q) : 16'sd0;
    in_c     = ch_q ? in_r_q : in_l_q;
    acc_c    = ch_q ? acc_r_q : acc_l_q;

    case (state_q)
      ST_SINE: begin
        mul_a = 28'(signed'({1'b0, rom_q}));
        mul_b = 22'(signed'({1'b0, mod_depth_q}));
      end
      ST_TAP_A: begin
        mul_a = 28'(tap_data);
        mul_b = 22'(signed'({1'b0, 9'd256 - {1'b0, f_q}}));
      end
      ST_TAP_B: begin
        mul_a = 28'(tap_data);
        mul_b = 22'(signed'({1'b0, f_q}));
      end
      ST_MIX_1: begin
        mul_a = 28'(in_c);
        mul_b = 22'(signed'({1'b0, 17'h10000 - {1'b0, wet_gain_q}}));
      end
      ST_MIX_2: begin
        mul_a = 28'(acc_c);
        mul_b = 22'(signed'({1'b0, wet_gain_q}));
      end
      ST_MIX_4: begin
        mul_a = 28'(signed'({1'b0, t_q}));
        mul_b = signed'(recip_scale(vcnt));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_d = 50'(mul_a) * 50'(mul_b);

    p8 = 45'(prod_q) <<< 8;
    case (vcnt)
      3'd2:    tmp_d = p8 <<< 1;
      3'd3:    tmp_d = p8 + (p8 <<< 1);
      3'd4:    tmp_d = p8 <<< 2;
      default: tmp_d = p8;
    endcase

    num = tmp_q + 45'(prod_q);
    mag = num[44] ? 45'(-num) : 45'(num);
    rnd = mag + (45'(vcnt) << 23);

    quo = prod_q[39:20];
    if (!sgn_q) begin
      sat = (quo > 20'd32767) ? 16'sh7fff : signed'(quo[15:0]);
    end else begin
      sat = (quo > 20'd32768) ? -16'sh8000 : signed'(16'(~quo[15:0] + 16'd1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      w_q         <= '0;
      full_q      <= 1'b0;
      lfo_q       <= '0;
      voice_q     <= '0;
      ch_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_WRITE: begin
          voice_q <= '0;
          ch_q    <= 1'b0;
        end
        ST_TAP_C: begin
          if (last_tap) begin
            ch_q <= 1'b0;
          end else begin
            ch_q <= !ch_q;
            if (ch_q) voice_q <= voice_q + 2'd1;
          end
        end
        ST_MIX_5: begin
          ch_q <= 1'b1;
          if (ch_q) begin
            w_q   <= w_q + 1'b1;
            lfo_q <= lfo_q + {8'b0, phase_step_q};
            if (&w_q) full_q <= 1'b1;
          end
        end
        default: ;
      endcase
      if (state_q == ST_DONE && out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    rom_q    <= SineRom[rom_addr];
    rvalid_q <= full_q || (rd_addr <= w_q);
    case (state_q)
      ST_IDLE: begin
        in_l_q  <= in_left_i;
        in_r_q  <= stereo_q ? in_right_i : in_left_i;
        res_l_q <= in_left_i;
        res_r_q <= stereo_q ? in_right_i : 16'sd0;
      end
      ST_WRITE: begin
        acc_l_q <= '0;
        acc_r_q <= '0;
      end
      ST_PHASE: neg_q <= ph[31];
      ST_DELAY: begin
        f_q      <= ffrac;
        addr_b_q <= addr_a - 1'b1;
      end
      ST_TAP_B, ST_TAP_C: begin
        if (ch_q) acc_r_q <= acc_r_q + prod_q[26:0];
        else      acc_l_q <= acc_l_q + prod_q[26:0];
      end
      ST_MIX_2: tmp_q <= tmp_d;
      ST_MIX_3: begin
        sgn_q <= num[44];
        t_q   <= rnd[43:24];
      end
      ST_MIX_5: begin
        if (ch_q) res_r_q <= stereo_q ? sat : 16'sd0;
        else      res_l_q <= sat;
      end
      default: ;
    endcase
    if (state_q == ST_DONE && out_load) begin
      out_l_q <= res_l_q;
      out_r_q <= res_r_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_WRITE) left_mem[w_q] <= in_l_q;
    rdl_q <= left_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_WRITE) right_mem[w_q] <= in_r_q;
    rdr_q <= right_mem[rd_addr];
  end

  assign out_valid_o = out_valid_q;
  assign out_left_o  = out_l_q;
  assign out_right_o = out_r_q;

endmodule
`default_nettype wire
